FILE: sv/amalm_pkg.sv
// amalm_pkg: shared constants, types and codes for the adc moving average level meter
// no dependencies
package amalm_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int SHORT_WINDOW = 8;
  localparam int LONG_WINDOW  = 16;

  localparam int SHORT_PTR_W = $clog2(SHORT_WINDOW);
  localparam int LONG_PTR_W  = $clog2(LONG_WINDOW);
  localparam int SHORT_TOT_W = SAMPLE_W + SHORT_PTR_W;
  localparam int LONG_TOT_W  = SAMPLE_W + LONG_PTR_W;

  localparam int BAR_W = 4;
  localparam int CV_W  = 9;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  // centivolts = floor((avg * 660 + 4095) / 8190)
  localparam int CV_NUM_W    = 22;
  localparam int CV_GAIN     = 660;
  localparam int CV_OFFSET   = 4095;
  localparam int CV_DIV      = 8190;
  localparam int RECIP_SHIFT = 35;
  localparam int RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP = 23'd4195330;
  localparam int CV_PROD_W   = CV_NUM_W + RECIP_W;
  localparam int CV_Q_W      = CV_PROD_W - RECIP_SHIFT;

  localparam logic [BAR_W-1:0] BAR_FOUR  = 4'b1111;
  localparam logic [BAR_W-1:0] BAR_THREE = 4'b1110;
  localparam logic [BAR_W-1:0] BAR_TWO   = 4'b1100;
  localparam logic [BAR_W-1:0] BAR_ONE   = 4'b1000;
  localparam logic [BAR_W-1:0] BAR_NONE  = 4'b0000;

  localparam logic [SAMPLE_W-1:0] LEVEL_ONE_RST   = 12'd819;
  localparam logic [SAMPLE_W-1:0] LEVEL_TWO_RST   = 12'd1638;
  localparam logic [SAMPLE_W-1:0] LEVEL_THREE_RST = 12'd2457;
  localparam logic [SAMPLE_W-1:0] LEVEL_FOUR_RST  = 12'd3276;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_ONE   = 2'd0,
    REG_LEVEL_TWO   = 2'd1,
    REG_LEVEL_THREE = 2'd2,
    REG_LEVEL_FOUR  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] one;
    logic [SAMPLE_W-1:0] two;
    logic [SAMPLE_W-1:0] three;
    logic [SAMPLE_W-1:0] four;
  } limits_t;

endpackage

FILE: sv/amalm_ram.sv
// amalm_ram: generic single write port, single read port synchronous ram
// read data registered, read of the entry being written returns the old value
module amalm_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/amalm_cfg.sv
// amalm_cfg: level limit register file written over the configuration channel
// depends on amalm_pkg
module amalm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [amalm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amalm_pkg::SAMPLE_W-1:0]  cfg_data,
  output amalm_pkg::limits_t            limits
);
  import amalm_pkg::*;

  limits_t limits_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.one   <= LEVEL_ONE_RST;
      limits_r.two   <= LEVEL_TWO_RST;
      limits_r.three <= LEVEL_THREE_RST;
      limits_r.four  <= LEVEL_FOUR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEVEL_ONE:   limits_r.one   <= cfg_data;
        REG_LEVEL_TWO:   limits_r.two   <= cfg_data;
        REG_LEVEL_THREE: limits_r.three <= cfg_data;
        REG_LEVEL_FOUR:  limits_r.four  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign limits = limits_r;

endmodule

FILE: sv/amalm_scale.sv
// amalm_scale: bar pattern, centivolt scaling and output register stages
// depends on amalm_pkg
module amalm_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          avg_valid,
  output logic                          avg_ready,
  input  logic [amalm_pkg::SAMPLE_W-1:0]  short_avg,
  input  logic [amalm_pkg::SAMPLE_W-1:0]  long_avg,
  input  amalm_pkg::limits_t            limits,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [11:0] short_average, [23:12] long_average, [27:24] bar_pattern,
  // [36:28] centivolts, [39:37] zero
  output logic [amalm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import amalm_pkg::*;

  logic                 v3_r;
  logic                 vo_r;
  logic                 rdy3;
  logic                 enter3;
  logic [BAR_W-1:0]     bar;
  logic [CV_NUM_W-1:0]  num;
  logic [CV_PROD_W-1:0] prod;

  logic [SAMPLE_W-1:0]  short3_r;
  logic [SAMPLE_W-1:0]  long3_r;
  logic [BAR_W-1:0]     bar3_r;
  logic [CV_NUM_W-1:0]  num3_r;
  logic [CV_Q_W-1:0]    qest3_r;

  logic [CV_NUM_W-1:0]  rem;
  logic [CV_Q_W-1:0]    q;

  logic [SAMPLE_W-1:0]  short_o_r;
  logic [SAMPLE_W-1:0]  long_o_r;
  logic [BAR_W-1:0]     bar_o_r;
  logic [CV_W-1:0]      cv_o_r;

  assign rdy3      = !vo_r || out_tready;
  assign avg_ready = !v3_r || rdy3;
  assign enter3    = avg_valid && avg_ready;

  // first limit not exceeded sets the pattern
  always_comb begin
    priority if (short_avg <= limits.one) begin
      bar = BAR_FOUR;
    end else if (short_avg <= limits.two) begin
      bar = BAR_THREE;
    end else if (short_avg <= limits.three) begin
      bar = BAR_TWO;
    end else if (short_avg <= limits.four) begin
      bar = BAR_ONE;
    end else begin
      bar = BAR_NONE;
    end
  end

  assign num  = CV_NUM_W'(short_avg) * CV_NUM_W'(CV_GAIN) + CV_NUM_W'(CV_OFFSET);
  assign prod = CV_PROD_W'(num) * CV_PROD_W'(RECIP);

  // reciprocal estimate is low by at most one
  assign rem = num3_r - CV_NUM_W'(qest3_r) * CV_NUM_W'(CV_DIV);
  assign q   = (rem >= CV_NUM_W'(CV_DIV)) ? qest3_r + CV_Q_W'(1) : qest3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v3_r <= enter3 || (v3_r && !rdy3);
      if (rdy3) begin
        vo_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enter3) begin
      short3_r <= short_avg;
      long3_r  <= long_avg;
      bar3_r   <= bar;
      num3_r   <= num;
      qest3_r  <= prod[CV_PROD_W-1:RECIP_SHIFT];
    end
    if (rdy3 && v3_r) begin
      short_o_r <= short3_r;
      long_o_r  <= long3_r;
      bar_o_r   <= bar3_r;
      cv_o_r    <= q[CV_W-1:0];
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = OUT_DATA_W'({cv_o_r, bar_o_r, long_o_r, short_o_r});

endmodule

FILE: sv/adc_moving_average_level_meter.sv
// adc_moving_average_level_meter: top level, ring memories and running totals
// depends on amalm_pkg, amalm_ram, amalm_cfg, amalm_scale
//
// Takes one 12-bit converter sample per word and returns one word per sample
// holding the 8-sample and 16-sample moving averages, a four-LED bar pattern
// from the short average and the short average in hundredths of a volt. A new
// sample is taken every cycle while the output is not stalled; each word passes
// a four-stage pipeline (ring memory read, running total update, scaling
// multiply, correction and output register). Both rings read as zero after
// reset until each slot is written, with no clearing pass. Limits are to be
// written over the cfg channel only while the block is idle; the block itself
// does not enforce this.
module adc_moving_average_level_meter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [11:0] sample, [15:12] zero
  input  logic [amalm_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [11:0] short_average, [23:12] long_average, [27:24] bar_pattern,
  // [36:28] centivolts, [39:37] zero
  output logic [amalm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [amalm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amalm_pkg::SAMPLE_W-1:0]   cfg_data
);
  import amalm_pkg::*;

  limits_t                 limits;
  logic                    accept;
  logic [SAMPLE_W-1:0]     sample;

  logic [SHORT_PTR_W-1:0]  sptr_r;
  logic [LONG_PTR_W-1:0]   lptr_r;
  logic [SHORT_WINDOW-1:0] svld_r;
  logic [LONG_WINDOW-1:0]  lvld_r;
  logic                    srvld_r;
  logic                    lrvld_r;
  logic [SAMPLE_W-1:0]     srd;
  logic [SAMPLE_W-1:0]     lrd;
  logic [SAMPLE_W-1:0]     sold;
  logic [SAMPLE_W-1:0]     lold;

  logic                    v1_r;
  logic [SAMPLE_W-1:0]     samp1_r;
  logic                    rdy1;
  logic                    adv1;

  logic                    v2_r;
  logic                    rdy2;
  logic [SHORT_TOT_W-1:0]  stot_r;
  logic [LONG_TOT_W-1:0]   ltot_r;

  amalm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  assign sample    = in_tdata[SAMPLE_W-1:0];
  assign rdy1      = !v2_r || rdy2;
  assign in_tready = !v1_r || rdy1;
  assign accept    = in_tvalid && in_tready;
  assign adv1      = v1_r && rdy1;

  amalm_ram #(.DEPTH(SHORT_WINDOW), .WIDTH(SAMPLE_W)) u_short_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (sptr_r),
    .wdata (sample),
    .re    (accept),
    .raddr (sptr_r),
    .rdata (srd)
  );

  amalm_ram #(.DEPTH(LONG_WINDOW), .WIDTH(SAMPLE_W)) u_long_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (lptr_r),
    .wdata (sample),
    .re    (accept),
    .raddr (lptr_r),
    .rdata (lrd)
  );

  // unwritten slots read as zero
  assign sold = srvld_r ? srd : '0;
  assign lold = lrvld_r ? lrd : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sptr_r  <= '0;
      lptr_r  <= '0;
      svld_r  <= '0;
      lvld_r  <= '0;
      srvld_r <= 1'b0;
      lrvld_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      stot_r  <= '0;
      ltot_r  <= '0;
    end else begin
      if (accept) begin
        sptr_r <= (sptr_r == SHORT_PTR_W'(SHORT_WINDOW - 1)) ? '0 : sptr_r + 1'b1;
        lptr_r <= (lptr_r == LONG_PTR_W'(LONG_WINDOW - 1)) ? '0 : lptr_r + 1'b1;
        svld_r[sptr_r] <= 1'b1;
        lvld_r[lptr_r] <= 1'b1;
        srvld_r <= svld_r[sptr_r];
        lrvld_r <= lvld_r[lptr_r];
      end
      v1_r <= accept || (v1_r && !rdy1);
      v2_r <= adv1 || (v2_r && !rdy2);
      if (adv1) begin
        stot_r <= stot_r + SHORT_TOT_W'(samp1_r) - SHORT_TOT_W'(sold);
        ltot_r <= ltot_r + LONG_TOT_W'(samp1_r) - LONG_TOT_W'(lold);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      samp1_r <= sample;
    end
  end

  amalm_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .avg_valid  (v2_r),
    .avg_ready  (rdy2),
    .short_avg  (SAMPLE_W'(stot_r / SHORT_WINDOW)),
    .long_avg   (SAMPLE_W'(ltot_r / LONG_WINDOW)),
    .limits     (limits),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
